/* design/lmrf_pkg.sv */
// Shared types and constants for the label map rectangle fill block.
// Used by lmrf_ctrl, lmrf_dp and label_map_rect_fill_top; depends on nothing else.

package lmrf_pkg;

    // Default geometry and label width.
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_LABEL_BITS = 8;

    // Fixed field widths of the ports.
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int POS_W     = 9;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_LBL_W = 8;

    // Command codes.
    localparam logic [OP_W-1:0] OP_FILL   = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Fill modes.
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IF_FREE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a command beat
        logic setup;    // form the row base address
        logic step;     // visit one cell of the rectangle
        logic rd_query; // read the queried cell
        logic clr;      // clear one cell after reset
        logic bump;     // advance the current label
        logic emit;     // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_fill;
        logic is_finish;
        logic query_ok;
        logic rect_empty;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

/* design/lmrf_ctrl.sv */
// Controller state machine for the label map rectangle fill block.
// Depends on lmrf_pkg for the command and status structs.

module lmrf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lmrf_pkg::t_sts  i_sts,
    output lmrf_pkg::t_cmd  o_cmd,
    output logic            o_stall
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_QRD   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_sts.is_fill && !i_sts.rect_empty) begin
                    n_state = S_FILL;
                end else if (i_sts.query_ok) begin
                    n_state = S_QRD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_FILL: begin
                o_cmd.step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RESP;
                end
            end
            S_QRD: begin
                o_cmd.rd_query = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bump = i_sts.is_finish;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Input beats are taken only while idle.
    assign o_stall = (r_state != S_IDLE);

endmodule

/* design/lmrf_dp.sv */
// Datapath for the label map rectangle fill block: map memory, geometry,
// rectangle walker, current label and result register. Depends on lmrf_pkg.

module lmrf_dp #(
    parameter int MAX_COLS   = lmrf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = lmrf_pkg::DEF_MAX_ROWS,
    parameter int LABEL_BITS = lmrf_pkg::DEF_LABEL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lmrf_pkg::t_cmd                     i_cmd,
    output lmrf_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_we,
    input  logic [lmrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  logic [lmrf_pkg::OP_W-1:0]          i_opcode,
    input  logic [lmrf_pkg::MODE_W-1:0]        i_fill_mode,
    input  logic signed [lmrf_pkg::POS_W-1:0]  i_pos_row,
    input  logic signed [lmrf_pkg::POS_W-1:0]  i_pos_col,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_span_rows,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_span_cols,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_cell_free,
    output logic [lmrf_pkg::OUT_LBL_W-1:0]     o_current_label
);

    localparam int DW        = lmrf_pkg::DIM_W;
    localparam int MAP_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW        = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam logic [LABEL_BITS-1:0] LABEL_MAX = {LABEL_BITS{1'b1}};

    // Geometry registers.
    logic [DW-1:0] r_cols;
    logic [DW-1:0] r_rows;
    logic [DW-1:0] cfg_val;

    // Captured command.
    logic [lmrf_pkg::OP_W-1:0]   r_op;
    logic [lmrf_pkg::MODE_W-1:0] r_mode;
    logic                        r_qok;
    logic                        r_empty;
    logic [DW-1:0]               r_left;
    logic [DW-1:0]               r_rend;
    logic [DW-1:0]               r_cend;

    // Walker.
    logic [DW-1:0] r_row;
    logic [DW-1:0] r_col;
    logic [AW-1:0] r_base;
    logic [AW-1:0] addr;
    logic [2*DW-1:0] prod;
    logic          row_end;
    logic          rect_last;

    // Memory and its ports.
    logic [LABEL_BITS-1:0] r_mem [MAP_CELLS];
    logic [LABEL_BITS-1:0] r_rdata;
    logic [AW-1:0]         r_clr;
    logic                  r_p_valid;
    logic [AW-1:0]         r_p_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [LABEL_BITS-1:0] mem_wdata;

    // Label and result.
    logic [LABEL_BITS-1:0]             r_label;
    logic [LABEL_BITS-1:0]             n_label;
    logic                              r_out_valid;
    logic                              r_out_free;
    logic [lmrf_pkg::OUT_LBL_W-1:0]    r_out_label;

    // Load-time bounds.
    logic [DW-1:0] top_c;
    logic [DW-1:0] left_c;
    logic [DW:0]   rend_sum;
    logic [DW:0]   cend_sum;
    logic [DW-1:0] rend_c;
    logic [DW-1:0] cend_c;
    logic          q_in;

    // A register value of zero counts as one; larger values stop at the maximum.
    always_comb begin
        cfg_val = i_cfg_wdata;
        if (cfg_val == '0) begin
            cfg_val = DW'(1);
        end
        if (i_cfg_index == lmrf_pkg::CFG_COLS) begin
            if (int'(cfg_val) > MAX_COLS) begin
                cfg_val = DW'(MAX_COLS);
            end
        end else begin
            if (int'(cfg_val) > MAX_ROWS) begin
                cfg_val = DW'(MAX_ROWS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= (256 > MAX_COLS) ? DW'(MAX_COLS) : DW'(256);
            r_rows <= (256 > MAX_ROWS) ? DW'(MAX_ROWS) : DW'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lmrf_pkg::CFG_COLS: r_cols <= cfg_val;
                lmrf_pkg::CFG_ROWS: r_rows <= cfg_val;
                default: ;
            endcase
        end
    end

    // Clamp the rectangle: a negative start goes to zero and keeps its span,
    // and the far edge stops at the map size in use.
    always_comb begin
        top_c    = i_pos_row[DW-1] ? '0 : DW'(i_pos_row);
        left_c   = i_pos_col[DW-1] ? '0 : DW'(i_pos_col);
        rend_sum = {1'b0, top_c} + {1'b0, i_span_rows};
        cend_sum = {1'b0, left_c} + {1'b0, i_span_cols};
        rend_c   = (rend_sum > {1'b0, r_rows}) ? r_rows : rend_sum[DW-1:0];
        cend_c   = (cend_sum > {1'b0, r_cols}) ? r_cols : cend_sum[DW-1:0];
        q_in     = !i_pos_row[DW-1] && !i_pos_col[DW-1] &&
                   (DW'(i_pos_row) < r_rows) && (DW'(i_pos_col) < r_cols);
    end

    // Capture a command beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_mode  <= i_fill_mode;
            r_qok   <= (i_opcode == lmrf_pkg::OP_QUERY) && q_in;
            r_empty <= (top_c >= rend_c) || (left_c >= cend_c) ||
                       (i_fill_mode > lmrf_pkg::MODE_CLEAR);
            r_left  <= left_c;
            r_rend  <= rend_c;
            r_cend  <= cend_c;
        end
    end

    // Row-major walk; the base address is formed once and then stepped.
    assign prod      = {{DW{1'b0}}, r_row} * {{DW{1'b0}}, r_cols};
    assign addr      = AW'(r_base + AW'(r_col));
    assign row_end   = ({1'b0, r_col} + 1'b1) == {1'b0, r_cend};
    assign rect_last = row_end && (({1'b0, r_row} + 1'b1) == {1'b0, r_rend});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= top_c;
            r_col <= left_c;
        end else if (i_cmd.setup) begin
            r_base <= AW'(prod);
        end else if (i_cmd.step) begin
            if (row_end) begin
                r_col  <= r_left;
                r_row  <= r_row + 1'b1;
                r_base <= AW'(r_base + AW'(r_cols));
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Clearing pass counter after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Write stage, in the cycle after the read of the same cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr <= addr;
    end

    // Memory write select: the clearing pass, else the fill write stage.
    always_comb begin
        if (i_cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_waddr = r_p_addr;
            mem_wdata = (r_mode == lmrf_pkg::MODE_CLEAR) ? '0 : r_label;
            case (r_mode)
                lmrf_pkg::MODE_WRITE:   mem_we = r_p_valid;
                lmrf_pkg::MODE_IF_FREE: mem_we = r_p_valid && (r_rdata == '0);
                lmrf_pkg::MODE_CLEAR:   mem_we = r_p_valid;
                default:                mem_we = 1'b0;
            endcase
        end
    end

    // Map memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.step || i_cmd.rd_query) begin
            r_rdata <= r_mem[addr];
        end
    end

    // Current label, saturating at its maximum.
    assign n_label = (r_label != LABEL_MAX) ? r_label + 1'b1 : r_label;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label <= LABEL_BITS'(1);
        end else if (i_cmd.bump) begin
            r_label <= n_label;
        end
    end

    // Result register; it is free when empty or when its beat is being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_free  <= r_qok && (r_rdata == '0);
            r_out_label <= lmrf_pkg::OUT_LBL_W'(i_cmd.bump ? n_label : r_label);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_free     = r_out_free;
    assign o_current_label = r_out_label;

    // Status to the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr == AW'(MAP_CELLS - 1));
        o_sts.is_fill    = (r_op == lmrf_pkg::OP_FILL);
        o_sts.is_finish  = (r_op == lmrf_pkg::OP_FINISH);
        o_sts.query_ok   = r_qok;
        o_sts.rect_empty = r_empty;
        o_sts.fill_last  = rect_last;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

/* design/label_map_rect_fill_top.sv */
// Top level of the label map rectangle fill block.
// Depends on lmrf_pkg, lmrf_ctrl and lmrf_dp.
//
//  channel   handshake             payload
//  command   i_valid / o_stall     i_opcode i_fill_mode i_pos_row i_pos_col
//                                  i_span_rows i_span_cols
//  result    o_valid / i_stall     o_cell_free o_current_label
//  config    i_cfg_we              i_cfg_index i_cfg_wdata
//
// A fill goes through setup, one cell of its clamped rectangle per cycle (the map
// memory has one read and one write port) and the response; an in-range query
// through setup, a cell read and the response; a finish, an empty fill or any
// other command through setup and the response. After reset a clearing pass
// writes every cell with command beats stalled; configuration writes are taken
// throughout. A result beat waiting under i_stall holds the block in S_RESP.

module label_map_rect_fill_top #(
    parameter int MAX_COLS   = lmrf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = lmrf_pkg::DEF_MAX_ROWS,
    parameter int LABEL_BITS = lmrf_pkg::DEF_LABEL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lmrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [lmrf_pkg::OP_W-1:0]          i_opcode,
    input  logic [lmrf_pkg::MODE_W-1:0]        i_fill_mode,
    input  logic signed [lmrf_pkg::POS_W-1:0]  i_pos_row,
    input  logic signed [lmrf_pkg::POS_W-1:0]  i_pos_col,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_span_rows,
    input  logic [lmrf_pkg::DIM_W-1:0]         i_span_cols,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_cell_free,
    output logic [lmrf_pkg::OUT_LBL_W-1:0]     o_current_label
);

    lmrf_pkg::t_cmd cmd;
    lmrf_pkg::t_sts sts;

    // Sequencer.
    lmrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // Map, walker and result register.
    lmrf_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .LABEL_BITS (LABEL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_fill_mode     (i_fill_mode),
        .i_pos_row       (i_pos_row),
        .i_pos_col       (i_pos_col),
        .i_span_rows     (i_span_rows),
        .i_span_cols     (i_span_cols),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_cell_free     (o_cell_free),
        .o_current_label (o_current_label)
    );

endmodule
